FILE: design/dwq_pkg.sv
// ----------------------------------------------------------------------------
// dwq_pkg: shared types and codes of the deduplicating wake queue
// Transaction payloads, command entries passed from the front end to the
// back end, and the operation and result kind codes.
// ----------------------------------------------------------------------------
package dwq_pkg;

   // Fixed field widths
   localparam int TASK_W = 5;
   localparam int KIND_W = 2;

   // Command queue between front end and back end
   localparam int CMD_DEPTH  = 4;
   // Wakes in flight: queued commands plus the one being drained
   localparam int WAKE_CNT_W = $clog2(CMD_DEPTH + 2);

   typedef logic [TASK_W-1:0] task_id_type;
   typedef logic [KIND_W-1:0] kind_type;

   // Request operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_WAKE = 1'b1;

   // Result kind codes
   localparam kind_type KIND_ADD   = 2'd0;
   localparam kind_type KIND_WOKEN = 2'd1;
   localparam kind_type KIND_EMPTY = 2'd2;

   // Command entry codes
   localparam logic [1:0] CMD_ANSWER = 2'd0;
   localparam logic [1:0] CMD_WAKE   = 2'd1;
   localparam logic [1:0] CMD_EMPTY  = 2'd2;

   typedef struct packed {
      logic        op;
      task_id_type task_id;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      task_id_type woken_task;
      logic        accepted;
      logic        last;
   } rsp_type;

   // For an answer: task_id is the request's task id. For a wake: task_id is
   // the first queued task and tail the last one.
   typedef struct packed {
      logic [1:0]  code;
      task_id_type task_id;
      logic        accepted;
      task_id_type tail;
   } cmd_type;

endpackage

FILE: design/dwq_ram.sv
// ----------------------------------------------------------------------------
// dwq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/dwq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dwq_cmd_fifo: command queue between front end and back end
// Small register FIFO of classified commands with a combinational head.
// ----------------------------------------------------------------------------
module dwq_cmd_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  dwq_pkg::cmd_type push_data,
   input  logic            pop,
   output dwq_pkg::cmd_type head_data,
   output logic            full,
   output logic            empty
);
   import dwq_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type          mem_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(CMD_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/dwq_front.sv
// ----------------------------------------------------------------------------
// dwq_front: request front end of the wake queue
// Checks queued marks, links new tasks at the tail, empties the queue on a
// wake and hands one classified command per request to the back end.
// ----------------------------------------------------------------------------
module dwq_front #(
   parameter int TASK_COUNT = 32,
   localparam int SLOTS = (TASK_COUNT < 32) ? TASK_COUNT : 32,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dwq_pkg::req_type     req_payload,
   input  logic                 fifo_full,
   output logic                 fifo_push,
   output dwq_pkg::cmd_type     fifo_data,
   input  logic                 wake_done,
   output logic                 link_wr_en,
   output logic [IDX_W-1:0]     link_wr_addr,
   output dwq_pkg::task_id_type link_wr_data
);
   import dwq_pkg::*;

   logic [SLOTS-1:0]      flags_ff, flags_in;
   task_id_type           head_ff, head_in;
   task_id_type           tail_ff, tail_in;
   logic                  nonempty_ff, nonempty_in;
   logic [WAKE_CNT_W-1:0] wakes_ff, wakes_in;

   logic             is_add;
   logic             in_range;
   logic [IDX_W-1:0] slot;
   logic             fresh;
   logic             links_tail;
   logic             take;

   // Classify the offered request
   assign is_add     = (req_payload.op == OP_ADD);
   assign in_range   = (32'(req_payload.task_id) < TASK_COUNT);
   assign slot       = IDX_W'(req_payload.task_id);
   assign fresh      = in_range && !flags_ff[slot];
   assign links_tail = is_add && fresh && nonempty_ff;

   // Hold a tail link write while a drain may still read the old links
   assign req_stall = fifo_full || (links_tail && (wakes_ff != '0));
   assign take      = req_valid && !req_stall;

   assign link_wr_en   = take && links_tail;
   assign link_wr_addr = IDX_W'(tail_ff);
   assign link_wr_data = req_payload.task_id;

   // Update queue state and build the command
   always_comb begin
      flags_in    = flags_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      nonempty_in = nonempty_ff;
      wakes_in    = wakes_ff;
      fifo_push   = take;
      fifo_data   = '{code: CMD_ANSWER, task_id: req_payload.task_id,
                      accepted: 1'b0, tail: '0};
      if (take) begin
         if (is_add) begin
            fifo_data.accepted = fresh;
            if (fresh) begin
               flags_in[slot] = 1'b1;
               if (!nonempty_ff) begin
                  head_in = req_payload.task_id;
               end
               tail_in     = req_payload.task_id;
               nonempty_in = 1'b1;
            end
         end else if (nonempty_ff) begin
            fifo_data   = '{code: CMD_WAKE, task_id: head_ff, accepted: 1'b0,
                            tail: tail_ff};
            flags_in    = '0;
            head_in     = '0;
            tail_in     = '0;
            nonempty_in = 1'b0;
         end else begin
            fifo_data = '{code: CMD_EMPTY, task_id: '0, accepted: 1'b0, tail: '0};
         end
      end
      // Count wakes handed over and not yet drained
      if (take && !is_add && nonempty_ff && !wake_done) begin
         wakes_in = wakes_ff + WAKE_CNT_W'(1);
      end else if (wake_done && !(take && !is_add && nonempty_ff)) begin
         wakes_in = wakes_ff - WAKE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         nonempty_ff <= 1'b0;
         wakes_ff    <= '0;
      end else begin
         flags_ff    <= flags_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         nonempty_ff <= nonempty_in;
         wakes_ff    <= wakes_in;
      end
   end

   // A link row is never rewritten while a drain is pending
   a_link_no_drain : assert property (@(posedge clock) disable iff (reset)
      link_wr_en |-> (wakes_ff == '0))
      else $error("link write while a wake drain is pending");

   // A wake of a nonempty queue leaves it empty with all marks clear
   a_wake_clears : assert property (@(posedge clock) disable iff (reset)
      (take && !is_add && nonempty_ff) |=> (flags_ff == '0) && !nonempty_ff)
      else $error("wake did not empty the queue");

   // Head and tail of a nonempty queue carry their queued marks
   a_ends_marked : assert property (@(posedge clock) disable iff (reset)
      nonempty_ff |-> (flags_ff[IDX_W'(head_ff)] && flags_ff[IDX_W'(tail_ff)]))
      else $error("queue end without queued mark");

endmodule

FILE: design/dwq_back.sv
// ----------------------------------------------------------------------------
// dwq_back: result back end of the wake queue
// Takes classified commands, answers adds and empty wakes, and drains a wake
// chain through the link table one task per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module dwq_back #(
   parameter int TASK_COUNT = 32,
   localparam int SLOTS = (TASK_COUNT < 32) ? TASK_COUNT : 32,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fifo_empty,
   input  dwq_pkg::cmd_type     fifo_head,
   output logic                 fifo_pop,
   output logic                 wake_done,
   output logic [IDX_W-1:0]     link_rd_addr,
   input  dwq_pkg::task_id_type link_rd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dwq_pkg::rsp_type     rsp_payload
);
   import dwq_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic        state_ff, state_in;
   task_id_type cur_ff, cur_in;
   task_id_type tail_ff, tail_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        adv;

   // Output slot is free or being taken this cycle
   assign adv = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      tail_in      = tail_ff;
      out_valid_in = adv ? 1'b0 : out_valid_ff;
      out_in       = out_ff;
      fifo_pop     = 1'b0;
      wake_done    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Take the next command
            if (adv && !fifo_empty) begin
               fifo_pop = 1'b1;
               case (fifo_head.code)
                  CMD_ANSWER: begin
                     out_valid_in = 1'b1;
                     out_in = '{kind: KIND_ADD, woken_task: fifo_head.task_id,
                                accepted: fifo_head.accepted, last: 1'b1};
                  end
                  CMD_WAKE: begin
                     state_in = ST_DRAIN;
                     cur_in   = fifo_head.task_id;
                     tail_in  = fifo_head.tail;
                  end
                  CMD_EMPTY: begin
                     out_valid_in = 1'b1;
                     out_in = '{kind: KIND_EMPTY, woken_task: '0,
                                accepted: 1'b0, last: 1'b1};
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            // Emit the current task and follow its link
            if (adv) begin
               out_valid_in = 1'b1;
               out_in = '{kind: KIND_WOKEN, woken_task: cur_ff,
                          accepted: 1'b0, last: (cur_ff == tail_ff)};
               if (cur_ff == tail_ff) begin
                  state_in  = ST_IDLE;
                  wake_done = 1'b1;
               end else begin
                  cur_in = link_rd_data;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Look up the successor of the next current task
   assign link_rd_addr = IDX_W'(cur_in);

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      tail_ff <= tail_in;
      out_ff  <= out_in;
   end

   // The end of a drain leaves its final woken result in the output slot
   a_done_last : assert property (@(posedge clock) disable iff (reset)
      wake_done |=> (out_valid_ff && out_ff.last && (out_ff.kind == KIND_WOKEN)))
      else $error("drain ended without a final woken result");

   // A non-final woken result only appears while the drain runs
   a_mid_drain : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.kind == KIND_WOKEN) && !out_ff.last)
         |-> (state_ff == ST_DRAIN))
      else $error("non-final woken result outside a drain");

   // A drain step always fills the output slot
   a_drain_emits : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && adv) |=> out_valid_ff)
      else $error("drain step produced no result");

endmodule

FILE: design/dedup_wake_queue_unit.sv
// ----------------------------------------------------------------------------
// dedup_wake_queue_unit: deduplicating pending-wake queue
// Top level: front end, command queue, link table RAM and back end.
// ----------------------------------------------------------------------------
// An add transaction is answered once with kind add, accepted set if the task
// was linked at the tail and clear if it was already queued or out of range.
// A wake transaction yields one woken result per queued task in insertion
// order, the final one flagged last, or a single empty result. The front end
// takes one request per cycle while its four-entry command queue has room;
// an add answer or empty result passes through the command queue and the
// registered output slot. A wake first loads its head into the back end and
// then drains one task per cycle while the output is not stalled, paced by
// the registered read of the link table RAM. An add that extends a nonempty
// queue waits at the input while an earlier wake still drains, since the
// drain reads the link rows it would rewrite. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module dedup_wake_queue_unit #(
   parameter int TASK_COUNT = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dwq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dwq_pkg::rsp_type rsp_payload
);
   import dwq_pkg::*;

   localparam int SLOTS = (TASK_COUNT < 32) ? TASK_COUNT : 32;
   localparam int IDX_W = $clog2(SLOTS);

   logic             fifo_push;
   cmd_type          fifo_wdata;
   logic             fifo_pop;
   cmd_type          fifo_head;
   logic             fifo_full;
   logic             fifo_empty;
   logic             wake_done;
   logic             link_wr_en;
   logic [IDX_W-1:0] link_wr_addr;
   task_id_type      link_wr_data;
   logic [IDX_W-1:0] link_rd_addr;
   task_id_type      link_rd_data;

   dwq_front #(.TASK_COUNT(TASK_COUNT)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .fifo_full    (fifo_full),
      .fifo_push    (fifo_push),
      .fifo_data    (fifo_wdata),
      .wake_done    (wake_done),
      .link_wr_en   (link_wr_en),
      .link_wr_addr (link_wr_addr),
      .link_wr_data (link_wr_data)
   );

   dwq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_wdata),
      .pop       (fifo_pop),
      .head_data (fifo_head),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   dwq_ram #(.WIDTH(TASK_W), .DEPTH(SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   dwq_back #(.TASK_COUNT(TASK_COUNT)) u_back (
      .clock        (clock),
      .reset        (reset),
      .fifo_empty   (fifo_empty),
      .fifo_head    (fifo_head),
      .fifo_pop     (fifo_pop),
      .wake_done    (wake_done),
      .link_rd_addr (link_rd_addr),
      .link_rd_data (link_rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule
